>>> rtl/assert_macros.svh
// Assertion macros shared by the page table frame allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define PTFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptfa_pkg.sv
// Types and constants of the page table frame allocator.
// Depends on nothing; imported by every module of the block.
package ptfa_pkg;

  localparam int PTFA_PAGE_INDEX_BITS = 4;
  localparam int PTFA_OFFSET_BITS     = 12;

  localparam int ADDR_W    = 16;
  localparam int FRAME_W   = 4;
  localparam int FU_W      = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [FU_W-1:0]  MAX_FRAMES         = 5'd16;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET  = 5'd16;
  localparam logic [CFG_W-1:0] PAGE_COUNT_RESET   = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VPAGE_COUNT  = 2'd1;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] virtual_address;
  } ptfa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  physical_address;
    logic [FRAME_W-1:0] frame;
    logic               page_fault;
    logic               evicted;
    logic [FRAME_W-1:0] victim_page;
    logic               victim_was_written;
    logic               no_victim;
  } ptfa_out_t;

  typedef enum logic [1:0] {
    SRC_HIT    = 2'd0,
    SRC_ALLOC  = 2'd1,
    SRC_VICTIM = 2'd2,
    SRC_NONE   = 2'd3
  } ptfa_src_t;

  typedef struct packed {
    logic      load;
    logic      rd_victim;
    logic      scan_clr;
    logic      scan_step;
    logic      commit;
    ptfa_src_t src;
  } ptfa_cmd_t;

  typedef struct packed {
    logic present;
    logic alloc_ok;
    logic scan_done;
    logic victim_found;
  } ptfa_sts_t;

endpackage

>>> rtl/ptfa_cfg.sv
// Configuration registers: frame limit and victim search length, saturated.
// Depends on ptfa_pkg.
module ptfa_cfg
  import ptfa_pkg::*;
#(
  parameter int PAGE_INDEX_BITS = PTFA_PAGE_INDEX_BITS,
  localparam int CNT_W = (PAGE_INDEX_BITS + 1 > CFG_W) ? PAGE_INDEX_BITS + 1 : CFG_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [FU_W-1:0]      frame_limit,
  output logic [CNT_W-1:0]     search_len
);

  localparam logic [CNT_W-1:0] PAGE_COUNT = CNT_W'(1 << PAGE_INDEX_BITS);

  logic [CFG_W-1:0] frame_count_r, frame_count_nxt;
  logic [CFG_W-1:0] vpage_count_r, vpage_count_nxt;
  logic [CNT_W-1:0] vpage_ext;

  assign cfg_ready = 1'b1;

  always_comb begin
    frame_count_nxt = frame_count_r;
    vpage_count_nxt = vpage_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_COUNT: frame_count_nxt = cfg_data;
        CFG_VPAGE_COUNT: vpage_count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RESET;
      vpage_count_r <= PAGE_COUNT_RESET;
    end else begin
      frame_count_r <= frame_count_nxt;
      vpage_count_r <= vpage_count_nxt;
    end
  end

  assign vpage_ext   = CNT_W'(vpage_count_r);
  assign frame_limit = (FU_W'(frame_count_r) > MAX_FRAMES) ? MAX_FRAMES
                                                           : FU_W'(frame_count_r);
  assign search_len  = (vpage_ext > PAGE_COUNT) ? PAGE_COUNT : vpage_ext;

endmodule

>>> rtl/ptfa_ctrl.sv
// Controller: sequences lookup, allocation, victim scan and commit.
// Depends on ptfa_pkg.
module ptfa_ctrl
  import ptfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ptfa_sts_t sts,
  output ptfa_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  ptfa_src_t src_r, src_nxt;

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    cmd           = '0;
    cmd.src       = src_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.present) begin
          src_nxt   = SRC_HIT;
          state_nxt = ST_COMMIT;
        end else if (sts.alloc_ok) begin
          src_nxt   = SRC_ALLOC;
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
          if (sts.victim_found) begin
            cmd.rd_victim = 1'b1;
            src_nxt       = SRC_VICTIM;
          end else begin
            src_nxt = SRC_NONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      src_r   <= SRC_HIT;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/ptfa_dp.sv
// Datapath: page flags, frame store, victim scan and result register.
// Depends on ptfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptfa_dp
  import ptfa_pkg::*;
#(
  parameter int PAGE_INDEX_BITS = PTFA_PAGE_INDEX_BITS,
  parameter int OFFSET_BITS     = PTFA_OFFSET_BITS,
  localparam int CNT_W = (PAGE_INDEX_BITS + 1 > CFG_W) ? PAGE_INDEX_BITS + 1 : CFG_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptfa_in_t         in_req,
  input  logic [FU_W-1:0]  frame_limit,
  input  logic [CNT_W-1:0] search_len,
  input  ptfa_cmd_t        cmd,
  output ptfa_sts_t        sts,
  output logic             out_strobe,
  output ptfa_out_t        out_res
);

  localparam int PAGE_COUNT = 1 << PAGE_INDEX_BITS;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_BITS) - 32'd1);

  logic                       mode_r;
  logic [ADDR_W-1:0]          va_r;
  logic [PAGE_INDEX_BITS-1:0] page;
  logic [ADDR_W-1:0]          offset;

  logic [PAGE_COUNT-1:0] present_r, present_nxt;
  logic [PAGE_COUNT-1:0] written_r, written_nxt;
  logic [FU_W-1:0]       frames_used_r, frames_used_nxt;

  logic [FRAME_W-1:0]         frame_mem [PAGE_COUNT];
  logic [FRAME_W-1:0]         rdata_r;
  logic [PAGE_INDEX_BITS-1:0] raddr;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       clean_found_r, clean_found_nxt;
  logic                       dirty_found_r, dirty_found_nxt;
  logic [PAGE_INDEX_BITS-1:0] clean_idx_r, clean_idx_nxt;
  logic [PAGE_INDEX_BITS-1:0] dirty_idx_r, dirty_idx_nxt;
  logic [PAGE_INDEX_BITS-1:0] scan_idx;
  logic [PAGE_INDEX_BITS-1:0] victim;

  logic [FRAME_W-1:0] frame_sel;
  logic [31:0]        pa_wide;
  logic               out_strobe_r;
  ptfa_out_t          out_r, out_nxt;

  assign page   = PAGE_INDEX_BITS'(va_r >> OFFSET_BITS);
  assign offset = va_r & OFF_MASK;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_req.is_write;
      va_r   <= in_req.virtual_address;
    end
  end

  assign victim = clean_found_r ? clean_idx_r : dirty_idx_r;
  assign raddr  = cmd.rd_victim ? victim : page;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      frame_mem[page] <= frame_sel;
    end
    rdata_r <= frame_mem[raddr];
  end

  assign scan_idx = cnt_r[PAGE_INDEX_BITS-1:0];

  always_comb begin
    cnt_nxt         = cnt_r;
    clean_found_nxt = clean_found_r;
    dirty_found_nxt = dirty_found_r;
    clean_idx_nxt   = clean_idx_r;
    dirty_idx_nxt   = dirty_idx_r;
    if (cmd.scan_clr) begin
      cnt_nxt         = '0;
      clean_found_nxt = 1'b0;
      dirty_found_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
      if (present_r[scan_idx] && (scan_idx != page)) begin
        if (!written_r[scan_idx] && !clean_found_r) begin
          clean_found_nxt = 1'b1;
          clean_idx_nxt   = scan_idx;
        end
        if (written_r[scan_idx] && !dirty_found_r) begin
          dirty_found_nxt = 1'b1;
          dirty_idx_nxt   = scan_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      clean_found_r <= 1'b0;
      dirty_found_r <= 1'b0;
    end else begin
      cnt_r         <= cnt_nxt;
      clean_found_r <= clean_found_nxt;
      dirty_found_r <= dirty_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clean_idx_r <= clean_idx_nxt;
    dirty_idx_r <= dirty_idx_nxt;
  end

  assign sts.present      = present_r[page];
  assign sts.alloc_ok     = (frames_used_r < frame_limit);
  assign sts.scan_done    = (cnt_r >= search_len) || clean_found_r;
  assign sts.victim_found = clean_found_r || dirty_found_r;

  always_comb begin
    case (cmd.src)
      SRC_HIT:    frame_sel = rdata_r;
      SRC_VICTIM: frame_sel = rdata_r;
      SRC_ALLOC:  frame_sel = frames_used_r[FRAME_W-1:0];
      default:    frame_sel = '0;
    endcase
  end

  always_comb begin
    present_nxt     = present_r;
    written_nxt     = written_r;
    frames_used_nxt = frames_used_r;
    if (cmd.commit) begin
      if (cmd.src == SRC_VICTIM) begin
        present_nxt[victim] = 1'b0;
        written_nxt[victim] = 1'b0;
      end
      if (cmd.src == SRC_ALLOC) begin
        frames_used_nxt = FU_W'(frames_used_r + FU_W'(1));
      end
      present_nxt[page] = 1'b1;
      written_nxt[page] = mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r     <= '0;
      written_r     <= '0;
      frames_used_r <= '0;
    end else begin
      present_r     <= present_nxt;
      written_r     <= written_nxt;
      frames_used_r <= frames_used_nxt;
    end
  end

  assign pa_wide = (32'(frame_sel) << OFFSET_BITS) | 32'(offset);

  always_comb begin
    out_nxt                    = '0;
    out_nxt.physical_address   = pa_wide[ADDR_W-1:0];
    out_nxt.frame              = frame_sel;
    out_nxt.page_fault         = (cmd.src != SRC_HIT);
    out_nxt.evicted            = (cmd.src == SRC_VICTIM);
    out_nxt.victim_page        = (cmd.src == SRC_VICTIM) ? FRAME_W'(victim) : '0;
    out_nxt.victim_was_written = (cmd.src == SRC_VICTIM) && !clean_found_r;
    out_nxt.no_victim          = (cmd.src == SRC_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;

  `PTFA_ASSERT(a_victim_not_self, clk, rst_n, (cmd.commit && cmd.src == SRC_VICTIM) |-> (victim != page), "victim is the accessed page")
  `PTFA_ASSERT(a_page_present, clk, rst_n, cmd.commit |=> present_r[$past(page)], "accessed page not present after commit")
  `PTFA_ASSERT_ALWAYS(a_frames_bound, clk, (!rst_n || (frames_used_r <= MAX_FRAMES)), "frame count overflow")
  `PTFA_ASSERT(a_scan_stops, clk, rst_n, cmd.scan_step |-> !sts.scan_done, "scan stepped past its end")

endmodule

>>> rtl/page_table_frame_allocator.sv
// Top level of the page table frame allocator: config, controller, datapath.
// Depends on ptfa_pkg, ptfa_cfg, ptfa_ctrl and ptfa_dp.
//
// Channel   Ports                                   Handshake
// request   start, busy, in_req                     start && !busy
// result    out_strobe, out_res                     out_strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// A hit or a free-frame allocation passes through lookup, decide and commit, and the result is registered at commit.
// A fault with all frames used adds a victim scan of one table entry a cycle,
// up to the search length, stopping at the first clean (unwritten) page.
// Reset clears page flags and frame count at once; no clearing pass.
// Results cannot be stalled; the result register lets a new request in.
module page_table_frame_allocator
  import ptfa_pkg::*;
#(
  parameter int PAGE_INDEX_BITS = PTFA_PAGE_INDEX_BITS,
  parameter int OFFSET_BITS     = PTFA_OFFSET_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ptfa_in_t             in_req,
  output logic                 out_strobe,
  output ptfa_out_t            out_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = (PAGE_INDEX_BITS + 1 > CFG_W) ? PAGE_INDEX_BITS + 1 : CFG_W;

  logic [FU_W-1:0]  frame_limit;
  logic [CNT_W-1:0] search_len;
  ptfa_cmd_t        cmd;
  ptfa_sts_t        sts;

  ptfa_cfg #(
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_limit (frame_limit),
    .search_len  (search_len)
  );

  ptfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptfa_dp #(
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .frame_limit (frame_limit),
    .search_len  (search_len),
    .cmd         (cmd),
    .sts         (sts),
    .out_strobe  (out_strobe),
    .out_res     (out_res)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of page_table_frame_allocator: directed and random accesses,
// with the translation predicted in a scoreboard class and checked field by field.
// Depends on ptfa_pkg and the page_table_frame_allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import ptfa_pkg::*;

  localparam int PAGES        = 1 << PTFA_PAGE_INDEX_BITS;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 138;
  localparam int RANDOM_PHASE = 10;
  localparam int DIRECTED_N   = 18;
  localparam int MAX_GAP      = 40;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  class translation_scoreboard;
    logic [FRAME_W-1:0] frame_of [PAGES];
    logic               present  [PAGES];
    logic               written  [PAGES];
    logic [FU_W-1:0]    frames_used;
    logic [CFG_W-1:0]   frame_limit;
    logic [CFG_W-1:0]   search_len;
    ptfa_out_t          expected_translations [$];
    int                 errors;

    function new();
      for (int i = 0; i < PAGES; i++) begin
        frame_of[i] = '0;
        present[i]  = 1'b0;
        written[i]  = 1'b0;
      end
      frames_used = '0;
      frame_limit = FRAME_COUNT_RESET;
      search_len  = PAGE_COUNT_RESET;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_FRAME_COUNT: frame_limit = val;
        CFG_VPAGE_COUNT: search_len = val;
        default: ;
      endcase
    endfunction

    function int find_victim(int self, int span, logic mode);
      for (int i = 0; i < span; i++)
        if (present[i] && written[i] == mode && i != self) return i;
      return -1;
    endfunction

    function int pending();
      return expected_translations.size();
    endfunction

    function void note_access(ptfa_in_t acc);
      logic [PTFA_PAGE_INDEX_BITS-1:0] page;
      logic [PTFA_OFFSET_BITS-1:0]     offs;
      logic [FU_W-1:0]                 lim;
      int                              span;
      int                              v;
      ptfa_out_t                       r;
      page = acc.virtual_address[ADDR_W-1 -: PTFA_PAGE_INDEX_BITS];
      offs = acc.virtual_address[PTFA_OFFSET_BITS-1:0];
      lim  = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      span = (int'(search_len) > PAGES) ? PAGES : int'(search_len);
      r    = '0;
      if (present[page]) begin
        r.frame = frame_of[page];
      end else begin
        r.page_fault = 1'b1;
        if (frames_used < lim) begin
          r.frame     = frames_used[FRAME_W-1:0];
          frames_used = frames_used + 1'b1;
        end else begin
          v = find_victim(int'(page), span, 1'b0);
          if (v < 0) v = find_victim(int'(page), span, 1'b1);
          if (v >= 0) begin
            r.evicted            = 1'b1;
            r.victim_page        = FRAME_W'(v);
            r.victim_was_written = written[v];
            r.frame              = frame_of[v];
            frame_of[v]          = '0;
            present[v]           = 1'b0;
            written[v]           = 1'b0;
          end else begin
            r.no_victim = 1'b1;
          end
        end
      end
      frame_of[page] = r.frame;
      present[page]  = 1'b1;
      written[page]  = acc.is_write;
      r.physical_address = ADDR_W'({r.frame, offs});
      expected_translations.push_back(r);
    endfunction

    function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ptfa_out_t got);
      ptfa_out_t want;
      if (expected_translations.size() == 0) begin
        $error("unexpected result: physical_address 0x%0h", got.physical_address);
        errors++;
        return;
      end
      want = expected_translations.pop_front();
      compare_field("physical_address", want.physical_address, got.physical_address);
      compare_field("frame", ADDR_W'(want.frame), ADDR_W'(got.frame));
      compare_field("page_fault", ADDR_W'(want.page_fault), ADDR_W'(got.page_fault));
      compare_field("evicted", ADDR_W'(want.evicted), ADDR_W'(got.evicted));
      compare_field("victim_page", ADDR_W'(want.victim_page), ADDR_W'(got.victim_page));
      compare_field("victim_was_written", ADDR_W'(want.victim_was_written),
                    ADDR_W'(got.victim_was_written));
      compare_field("no_victim", ADDR_W'(want.no_victim), ADDR_W'(got.no_victim));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ptfa_in_t             in_req;
  logic                 out_strobe;
  ptfa_out_t            out_res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   cycle_count = 0;

  translation_scoreboard xlat_sb;

  page_table_frame_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_strobe) xlat_sb.check_result(out_res);

  task automatic issue(ptfa_in_t acc);
    start  <= 1'b1;
    in_req <= acc;
    do @(posedge clk); while (busy);
    xlat_sb.note_access(acc);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (xlat_sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    xlat_sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ptfa_in_t random_access();
    ptfa_in_t                        acc;
    logic [PTFA_PAGE_INDEX_BITS-1:0] page;
    logic [PTFA_OFFSET_BITS-1:0]     offs;
    page = ($urandom_range(99) < 65) ? PTFA_PAGE_INDEX_BITS'($urandom_range(5))
                                     : PTFA_PAGE_INDEX_BITS'($urandom_range(PAGES - 1));
    case ($urandom_range(9))
      0:       offs = '0;
      1:       offs = '1;
      default: offs = PTFA_OFFSET_BITS'($urandom);
    endcase
    acc.is_write        = 1'($urandom_range(1));
    acc.virtual_address = ADDR_W'({page, offs});
    return acc;
  endfunction

  ptfa_in_t directed [DIRECTED_N] = '{
    '{1'b0, 16'h0000}, '{1'b1, 16'h0FFF}, '{1'b1, 16'hFFFF}, '{1'b0, 16'hF000},
    '{1'b0, 16'h1234}, '{1'b1, 16'h8001}, '{1'b0, 16'h7FFE}, '{1'b0, 16'h2ABC},
    '{1'b1, 16'h3000}, '{1'b0, 16'h2ABC}, '{1'b1, 16'h4444}, '{1'b0, 16'h5555},
    '{1'b1, 16'h6666}, '{1'b0, 16'h9FFF}, '{1'b1, 16'hA000}, '{1'b0, 16'h5000},
    '{1'b1, 16'hB123}, '{1'b0, 16'h0ABC}
  };

  int phase_frames [PHASES] = '{31, 16, 3, 1, 0, 16, 2, 5, 17, 4, 0, 16};
  int phase_search [PHASES] = '{31, 16, 16, 5, 16, 0, 1, 12, 3, 16, 0, 16};

  initial begin
    logic [CFG_W-1:0] fc;
    logic [CFG_W-1:0] vc;
    int               pct;
    int               gap;
    xlat_sb   = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      case (i)
        7:  begin wait_drained(); write_reg(CFG_FRAME_COUNT, 5'd3); end
        11: begin wait_drained(); write_reg(CFG_VPAGE_COUNT, 5'd0); end
        13: begin
          wait_drained();
          write_reg(CFG_VPAGE_COUNT, 5'd31);
          write_reg(CFG_FRAME_COUNT, 5'd0);
        end
        16: begin wait_drained(); write_reg(CFG_VPAGE_COUNT, 5'd1); end
        default: ;
      endcase
      issue(directed[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      fc  = (p == RANDOM_PHASE) ? CFG_W'($urandom_range(31)) : CFG_W'(phase_frames[p]);
      vc  = (p == RANDOM_PHASE) ? CFG_W'($urandom_range(31)) : CFG_W'(phase_search[p]);
      pct = (p < 4) ? 26 : ((p < 8) ? 61 : 0);
      wait_drained();
      if (p == 5) write_reg(CFG_UNUSED_IDX, CFG_W'($urandom_range(31)));
      write_reg(CFG_FRAME_COUNT, fc);
      write_reg(CFG_VPAGE_COUNT, vc);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        issue(random_access());
        if (k == PHASE_ITEMS / 2 && p % 3 == 0) begin
          wait_drained();
        end else begin
          gap = 0;
          while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
          if (gap > 0) pause_sender(gap);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (xlat_sb.errors == 0 && xlat_sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ptfa_pkg.sv
rtl/ptfa_cfg.sv
rtl/ptfa_ctrl.sv
rtl/ptfa_dp.sv
rtl/page_table_frame_allocator.sv
dv/tb_top.sv
